// ===== rtl/tlpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpc_pkg
// Types and constants shared by the traffic light phase controller.
// ----------------------------------------------------------------------------
package tlpc_pkg;

  localparam int unsigned TimeW  = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_MAINT = 2'd1,
    FUNC_BLINK = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PH_ALL_RED_A = 3'd0,
    PH_TURN_NS   = 3'd1,
    PH_GREEN_NS  = 3'd2,
    PH_YELLOW_NS = 3'd3,
    PH_ALL_RED_B = 3'd4,
    PH_TURN_EW   = 3'd5,
    PH_GREEN_EW  = 3'd6,
    PH_YELLOW_EW = 3'd7
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHORT_PHASE_TIME = 2'd0,
    CFG_TURN_PHASE_TIME  = 2'd1,
    CFG_GREEN_MAX_TIME   = 2'd2,
    CFG_GREEN_MIN_TIME   = 2'd3
  } cfg_idx_e;

  localparam logic [TimeW-1:0] ShortPhaseTimeRst = 8'd3;
  localparam logic [TimeW-1:0] TurnPhaseTimeRst  = 8'd5;
  localparam logic [TimeW-1:0] GreenMaxTimeRst   = 8'd10;
  localparam logic [TimeW-1:0] GreenMinTimeRst   = 8'd5;

  typedef struct packed {
    logic [TimeW-1:0] short_phase_time;
    logic [TimeW-1:0] turn_phase_time;
    logic [TimeW-1:0] green_max_time;
    logic [TimeW-1:0] green_min_time;
  } cfg_t;

  typedef struct packed {
    func_e            func;
    logic [TimeW-1:0] time_in_phase;
    logic             walk_request_ns;
    logic             walk_request_ew;
    logic             emergency_ns;
    logic             emergency_ew;
  } item_t;

  // Packed MSB first: red_ns is bit 0, red_ew bit 7.
  typedef struct packed {
    logic red_ew;
    logic yellow_ew;
    logic green_ew;
    logic turn_ew;
    logic turn_ns;
    logic green_ns;
    logic yellow_ns;
    logic red_ns;
  } lamp_t;

endpackage

// ===== rtl/tlpc_in_if.sv =====
// ----------------------------------------------------------------------------
// tlpc_in_if
// Event word channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
interface tlpc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] time_in_phase;
  logic       walk_request_ns;
  logic       walk_request_ew;
  logic       emergency_ns;
  logic       emergency_ew;

  modport source (
    output valid, func, time_in_phase, walk_request_ns, walk_request_ew,
           emergency_ns, emergency_ew,
    input  ready
  );
  modport sink (
    input  valid, func, time_in_phase, walk_request_ns, walk_request_ew,
           emergency_ns, emergency_ew,
    output ready
  );
endinterface

// ===== rtl/tlpc_out_if.sv =====
// ----------------------------------------------------------------------------
// tlpc_out_if
// Result word channel: valid/ready handshake with phase and lamp fields.
// ----------------------------------------------------------------------------
interface tlpc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase_now;
  logic       lamp_red_ns;
  logic       lamp_yellow_ns;
  logic       lamp_green_ns;
  logic       lamp_turn_ns;
  logic       lamp_turn_ew;
  logic       lamp_green_ew;
  logic       lamp_yellow_ew;
  logic       lamp_red_ew;

  modport source (
    output valid, phase_now, lamp_red_ns, lamp_yellow_ns, lamp_green_ns,
           lamp_turn_ns, lamp_turn_ew, lamp_green_ew, lamp_yellow_ew,
           lamp_red_ew,
    input  ready
  );
  modport sink (
    input  valid, phase_now, lamp_red_ns, lamp_yellow_ns, lamp_green_ns,
           lamp_turn_ns, lamp_turn_ew, lamp_green_ew, lamp_yellow_ew,
           lamp_red_ew,
    output ready
  );
endinterface

// ===== rtl/traffic_light_phase_controller.sv =====
// Accepts one event word per clock while the output is not stalled and returns
// one result word per event, in order, via the input register and then the core
// state registers. The rate is set by the phase and lamp update, whose state
// registers also hold the result word; an input register in front lets a new
// word enter while a result waits to be taken. Timing registers are written
// through the cfg port and should only change while no event is in flight.
// ----------------------------------------------------------------------------
// traffic_light_phase_controller
// Two-road eight-phase traffic light controller, top level.
// ----------------------------------------------------------------------------
module traffic_light_phase_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tlpc_in_if.sink                      in_if,
  tlpc_out_if.source                   out_if,
  input  logic                         cfg_we_i,
  input  logic [tlpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tlpc_pkg::TimeW-1:0]   cfg_wdata_i
);

  tlpc_pkg::cfg_t  cfg;
  tlpc_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  tlpc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tlpc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  tlpc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .out_if       (out_if)
  );

endmodule

// ===== rtl/tlpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tlpc_cfg_regs
// Timing configuration registers with a plain write port.
// ----------------------------------------------------------------------------
module tlpc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tlpc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tlpc_pkg::TimeW-1:0]          cfg_wdata_i,
  output tlpc_pkg::cfg_t                      cfg_o
);

  tlpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tlpc_pkg::cfg_idx_e'(cfg_idx_i))
        tlpc_pkg::CFG_SHORT_PHASE_TIME: cfg_d.short_phase_time = cfg_wdata_i;
        tlpc_pkg::CFG_TURN_PHASE_TIME:  cfg_d.turn_phase_time  = cfg_wdata_i;
        tlpc_pkg::CFG_GREEN_MAX_TIME:   cfg_d.green_max_time   = cfg_wdata_i;
        tlpc_pkg::CFG_GREEN_MIN_TIME:   cfg_d.green_min_time   = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_phase_time <= tlpc_pkg::ShortPhaseTimeRst;
      cfg_q.turn_phase_time  <= tlpc_pkg::TurnPhaseTimeRst;
      cfg_q.green_max_time   <= tlpc_pkg::GreenMaxTimeRst;
      cfg_q.green_min_time   <= tlpc_pkg::GreenMinTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tlpc_in_reg.sv =====
// ----------------------------------------------------------------------------
// tlpc_in_reg
// Input register stage for event words; passes one word per cycle while the core is ready.
// ----------------------------------------------------------------------------
module tlpc_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  tlpc_in_if.sink         in_if,
  output logic            item_valid_o,
  output tlpc_pkg::item_t item_o,
  input  logic            item_ready_i
);

  logic            valid_q, valid_d;
  tlpc_pkg::item_t item_q, item_d;
  logic            load;

  assign in_if.ready = !valid_q || item_ready_i;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_if.ready) begin
      valid_d = in_if.valid;
    end
    if (load) begin
      item_d.func            = tlpc_pkg::func_e'(in_if.func);
      item_d.time_in_phase   = in_if.time_in_phase;
      item_d.walk_request_ns = in_if.walk_request_ns;
      item_d.walk_request_ew = in_if.walk_request_ew;
      item_d.emergency_ns    = in_if.emergency_ns;
      item_d.emergency_ew    = in_if.emergency_ew;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/tlpc_core.sv =====
// ----------------------------------------------------------------------------
// tlpc_core
// Phase and lamp update; the state registers double as the result register.
// ----------------------------------------------------------------------------
module tlpc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tlpc_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  tlpc_pkg::item_t item_i,
  output logic            item_ready_o,
  tlpc_out_if.source      out_if
);

  tlpc_pkg::phase_e phase_q, phase_d, phase_step;
  tlpc_pkg::lamp_t  lamp_q, lamp_d, lamp_step;
  logic             valid_q, valid_d;
  logic             go;
  logic             take;

  assign item_ready_o = !valid_q || out_if.ready;
  assign take         = item_valid_i && item_ready_o;

  // next phase
  always_comb begin
    go = 1'b0;
    case (phase_q)
      tlpc_pkg::PH_ALL_RED_A, tlpc_pkg::PH_YELLOW_NS,
      tlpc_pkg::PH_ALL_RED_B, tlpc_pkg::PH_YELLOW_EW: begin
        go = item_i.time_in_phase >= cfg_i.short_phase_time;
      end
      tlpc_pkg::PH_TURN_NS, tlpc_pkg::PH_TURN_EW: begin
        go = item_i.time_in_phase >= cfg_i.turn_phase_time;
      end
      tlpc_pkg::PH_GREEN_NS: begin
        go = (item_i.time_in_phase >= cfg_i.green_max_time) ||
             ((item_i.time_in_phase >= cfg_i.green_min_time) && item_i.walk_request_ns);
      end
      tlpc_pkg::PH_GREEN_EW: begin
        go = (item_i.time_in_phase >= cfg_i.green_max_time) ||
             ((item_i.time_in_phase >= cfg_i.green_min_time) && item_i.walk_request_ew);
      end
      default: go = 1'b0;
    endcase

    if (item_i.emergency_ns) begin
      phase_step = tlpc_pkg::PH_GREEN_NS;
    end else if (item_i.emergency_ew) begin
      phase_step = tlpc_pkg::PH_GREEN_EW;
    end else if (go) begin
      phase_step = tlpc_pkg::phase_e'(3'(phase_q + 3'd1));
    end else begin
      phase_step = phase_q;
    end
  end

  // lamp decode for the new phase
  always_comb begin
    lamp_step = '0;
    case (phase_step)
      tlpc_pkg::PH_TURN_NS: begin
        lamp_step.red_ns  = 1'b1;
        lamp_step.red_ew  = 1'b1;
        lamp_step.turn_ns = !lamp_q.turn_ns;
      end
      tlpc_pkg::PH_GREEN_NS: begin
        lamp_step.green_ns = 1'b1;
        lamp_step.red_ew   = 1'b1;
      end
      tlpc_pkg::PH_YELLOW_NS: begin
        lamp_step.yellow_ns = 1'b1;
        lamp_step.red_ew    = 1'b1;
      end
      tlpc_pkg::PH_TURN_EW: begin
        lamp_step.red_ns  = 1'b1;
        lamp_step.red_ew  = 1'b1;
        lamp_step.turn_ew = !lamp_q.turn_ew;
      end
      tlpc_pkg::PH_GREEN_EW: begin
        lamp_step.red_ns   = 1'b1;
        lamp_step.green_ew = 1'b1;
      end
      tlpc_pkg::PH_YELLOW_EW: begin
        lamp_step.red_ns    = 1'b1;
        lamp_step.yellow_ew = 1'b1;
      end
      default: begin
        lamp_step.red_ns = 1'b1;
        lamp_step.red_ew = 1'b1;
      end
    endcase
  end

  // event dispatch
  always_comb begin
    phase_d = phase_q;
    lamp_d  = lamp_q;
    valid_d = valid_q;
    if (item_ready_o) begin
      valid_d = item_valid_i;
    end
    if (take) begin
      case (item_i.func)
        tlpc_pkg::FUNC_STEP: begin
          phase_d = phase_step;
          lamp_d  = lamp_step;
        end
        tlpc_pkg::FUNC_MAINT: begin
          lamp_d        = '0;
          lamp_d.red_ns = 1'b1;
          lamp_d.red_ew = 1'b1;
        end
        tlpc_pkg::FUNC_BLINK: begin
          lamp_d        = '0;
          lamp_d.red_ns = !lamp_q.red_ns;
          lamp_d.red_ew = !lamp_q.red_ew;
        end
        default: begin
          phase_d = phase_q;
          lamp_d  = lamp_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= tlpc_pkg::PH_ALL_RED_A;
      lamp_q  <= '0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
      lamp_q  <= lamp_d;
    end
  end

  assign out_if.valid          = valid_q;
  assign out_if.phase_now      = phase_q;
  assign out_if.lamp_red_ns    = lamp_q.red_ns;
  assign out_if.lamp_yellow_ns = lamp_q.yellow_ns;
  assign out_if.lamp_green_ns  = lamp_q.green_ns;
  assign out_if.lamp_turn_ns   = lamp_q.turn_ns;
  assign out_if.lamp_turn_ew   = lamp_q.turn_ew;
  assign out_if.lamp_green_ew  = lamp_q.green_ew;
  assign out_if.lamp_yellow_ew = lamp_q.yellow_ew;
  assign out_if.lamp_red_ew    = lamp_q.red_ew;

endmodule
